// File: hw/rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg: shared types and constants for the ordered list store
// Holds the store depth, the command and status codes, the cell operation
// codes and the control word that the top level sends along the cell chain.
// ----------------------------------------------------------------------------
package olst_pkg;

  // store depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 10;
  localparam int STAT_W   = 3;
  localparam int OCC_W    = 11;

  // command codes
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_POS  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LIST     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OOB     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  // cell operations
  localparam int CELL_OP_W = 3;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;  // keep contents
  localparam logic [CELL_OP_W-1:0] CELL_PUSH   = 3'd1;  // shift toward tail, new head
  localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 3'd2;  // write one cell at sel
  localparam logic [CELL_OP_W-1:0] CELL_PULL   = 3'd3;  // cells from sel on take next
  localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 3'd4;  // rotate cells 0..sel

  // control word broadcast to every cell
  typedef struct packed {
    logic [CELL_OP_W-1:0]     op;
    logic [IDX_W-1:0]         sel;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the list chain
// Holds one element and, per control word, keeps it, loads a new value or
// takes the word of its left neighbor, right neighbor or the head cell.
// ----------------------------------------------------------------------------
module olst_cell
  import olst_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] head_data,
  output logic signed [DATA_W-1:0] data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // next word select
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_HOLD:  data_nxt = data_r;
      CELL_PUSH:  data_nxt = (idx == '0) ? ctrl.value : left_data;
      CELL_WRITE: data_nxt = (idx == ctrl.sel) ? ctrl.value : data_r;
      CELL_PULL:  data_nxt = (idx >= ctrl.sel) ? right_data : data_r;
      CELL_ROTATE: begin
        if (idx < ctrl.sel) begin
          data_nxt = right_data;
        end else if (idx == ctrl.sel) begin
          data_nxt = head_data;
        end
      end
      default:    data_nxt = data_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hw/rtl/ordered_list_store.sv
// The result word is registered: the first one appears in the cycle after a
// command is taken. Inserts, deletes and errors give one word and the next
// command is taken in the following cycle. A listing of n elements gives n
// words without gaps while the element chain rotates one cell per cycle,
// and busy stays high meanwhile. Results cannot be stalled by the receiver.
// Reset clears the element count, the listing counter and the result strobe.
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list held in a chain of cells
// Cell 0 is the head. Head inserts and deletes shift the chain and tail
// inserts write one cell; listing reads cell 0 as occupied cells rotate.
// ----------------------------------------------------------------------------
module ordered_list_store
  import olst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic [OCC_W-1:0]         out_occupancy,
  output logic                     out_last
);

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  cell_ctrl_t               ctrl;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         list_cnt_r, list_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_element_r, out_element_nxt;
  logic [OCC_W-1:0]         out_occupancy_r;
  logic                     out_last_r, out_last_nxt;

  logic                     accept;
  logic [IDX_W-1:0]         rd_sel;
  logic [POS_W:0]           pos_x;
  logic [POS_W:0]           cnt_x;
  logic [IDX_W-1:0]         tail_idx;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_data[0];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[CAPACITY-1];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    olst_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_w),
      .right_data (right_w),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  assign busy   = (list_cnt_r != '0);
  assign accept = start && !busy;
  assign pos_x  = {1'b0, in_position};
  assign cnt_x  = (POS_W + 1)'(count_r);
  assign tail_idx = IDX_W'(count_r - CNT_W'(1));

  // read select for deletes
  always_comb begin
    case (in_kind)
      KIND_DEL_TAIL: rd_sel = tail_idx;
      KIND_DEL_POS:  rd_sel = IDX_W'(in_position - POS_W'(1));
      default:       rd_sel = '0;
    endcase
  end

  // command decode and result word
  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.sel        = '0;
    ctrl.value      = in_value;
    count_nxt       = count_r;
    list_cnt_nxt    = list_cnt_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = STAT_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    if (busy) begin
      // listing in progress
      out_valid_nxt   = 1'b1;
      out_element_nxt = cell_data[0];
      out_last_nxt    = (list_cnt_r == CNT_W'(1));
      list_cnt_nxt    = list_cnt_r - CNT_W'(1);
      ctrl.op         = CELL_ROTATE;
      ctrl.sel        = tail_idx;
    end else if (start) begin
      out_valid_nxt = 1'b1;
      case (in_kind)
        KIND_INS_HEAD, KIND_INS_TAIL: begin
          if (count_r >= CNT_W'(CAPACITY)) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ctrl.op   = (in_kind == KIND_INS_HEAD) ? CELL_PUSH : CELL_WRITE;
            ctrl.sel  = IDX_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_POS: begin
          if (count_r == '0) begin
            out_status_nxt = STAT_EMPTY;
          end else if (in_kind == KIND_DEL_POS && in_position == '0) begin
            out_status_nxt = STAT_BAD_POS;
          end else if (in_kind == KIND_DEL_POS && pos_x > cnt_x) begin
            out_status_nxt = STAT_OOB;
          end else begin
            out_element_nxt = cell_data[rd_sel];
            ctrl.op         = CELL_PULL;
            ctrl.sel        = rd_sel;
            count_nxt       = count_r - CNT_W'(1);
          end
        end
        KIND_LIST: begin
          if (count_r == '0) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_element_nxt = cell_data[0];
            out_last_nxt    = (count_r == CNT_W'(1));
            list_cnt_nxt    = count_r - CNT_W'(1);
            ctrl.op         = CELL_ROTATE;
            ctrl.sel        = tail_idx;
          end
        end
        default: begin
          out_status_nxt = STAT_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      list_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      list_cnt_r  <= list_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_status_r    <= out_status_nxt;
    out_element_r   <= out_element_nxt;
    out_occupancy_r <= OCC_W'(count_nxt);
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_element   = out_element_r;
  assign out_occupancy = out_occupancy_r;
  assign out_last      = out_last_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command gave no result word");

  a_list_streams: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("listing cycle gave no result word");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("listing stopped before its last word");

endmodule
